>>> hdl/rbd_pkg.sv
// rbd_pkg: shared constants, configuration register codes and payload types
// for the RGB box downscaler. Depends on nothing; every other file uses it.
`default_nettype none

package rbd_pkg;

  // Default sizing of the block
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_FACTOR = 16;

  // One color channel
  localparam int PIX_W = 8;

  // Configuration port
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;
  localparam int FACTOR_REG_W = 5;
  localparam int WIDTH_REG_W  = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FACTOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b1;

  // Register values after reset
  localparam int FACTOR_RST = 2;
  localparam int WIDTH_RST  = 640;

  // Entries in the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rbd_pix_t;

  // Classification the front attaches to each pixel it queues
  typedef struct packed {
    logic first;    // first pixel of its block: start a fresh sum
    logic emit;     // last pixel of its block: produce a mean
    logic row_end;  // block is the last one of its output row
  } rbd_flags_t;

endpackage

`default_nettype wire

>>> hdl/rbd_if.sv
// rbd_in_if / rbd_out_if: valid/ready channels for source pixels and for
// block means. Depends on rbd_pkg.
`default_nettype none

interface rbd_in_if;
  logic                     valid;
  logic                     ready;
  logic [rbd_pkg::PIX_W-1:0] in_red;
  logic [rbd_pkg::PIX_W-1:0] in_green;
  logic [rbd_pkg::PIX_W-1:0] in_blue;
  logic                     frame_start;

  modport source (output valid, in_red, in_green, in_blue, frame_start, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, frame_start, output ready);
endinterface

interface rbd_out_if;
  logic                     valid;
  logic                     ready;
  logic [rbd_pkg::PIX_W-1:0] out_red;
  logic [rbd_pkg::PIX_W-1:0] out_green;
  logic [rbd_pkg::PIX_W-1:0] out_blue;
  logic                     row_end;

  modport source (output valid, out_red, out_green, out_blue, row_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, row_end, output ready);
endinterface

`default_nettype wire

>>> hdl/rbd_front.sv
// rbd_front: raster position counters; classifies each accepted pixel
// (block start, block end, row end, inside kept area). Depends on rbd_pkg, rbd_if.
`default_nettype none

module rbd_front #(
  parameter int MAX_WIDTH  = rbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = rbd_pkg::DEF_MAX_FACTOR
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [$clog2(MAX_FACTOR+1)-1:0] f_eff,
  input  wire logic [$clog2(MAX_WIDTH):0]      w_eff,
  rbd_in_if.sink                              in_ch,
  output logic                                push_valid,
  input  wire logic                           push_ready,
  output logic [$clog2(MAX_WIDTH)-1:0]        push_addr,
  output rbd_pkg::rbd_pix_t                   push_pix,
  output rbd_pkg::rbd_flags_t                 push_flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_FACTOR + 1);
  localparam int KW = $clog2(MAX_FACTOR);
  localparam int PW = CW + FW + 1;

  logic [CW-1:0] src_col_r, src_col_nxt, src_cur;
  logic [CW-1:0] out_col_r, out_col_nxt, out_cur;
  logic [KW-1:0] row_r, row_nxt, row_cur;
  logic [KW-1:0] col_r, col_nxt, col_cur;

  logic          accept;
  logic [PW-1:0] blk_base;
  logic [PW-1:0] f_ext;
  logic          active;
  logic          last_blk;
  logic [FW:0]   row_inc;
  logic [FW:0]   col_inc;
  logic [CW:0]   src_inc;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  // frame_start clears the position before the pixel is placed
  always_comb begin
    src_cur = in_ch.frame_start ? '0 : src_col_r;
    out_cur = in_ch.frame_start ? '0 : out_col_r;
    row_cur = in_ch.frame_start ? '0 : row_r;
    col_cur = in_ch.frame_start ? '0 : col_r;
  end

  // Block covers source columns blk_base .. blk_base+F-1; kept if it fits in W
  assign f_ext    = PW'(f_eff);
  assign blk_base = PW'(out_cur) * f_ext;
  assign active   = (blk_base + f_ext) <= PW'(w_eff);
  assign last_blk = (blk_base + f_ext + f_ext) > PW'(w_eff);

  assign row_inc = (FW+1)'(row_cur) + (FW+1)'(1);
  assign col_inc = (FW+1)'(col_cur) + (FW+1)'(1);
  assign src_inc = (CW+1)'(src_cur) + (CW+1)'(1);

  // Queue payload
  always_comb begin
    push_valid         = in_ch.valid && active;
    push_addr          = out_cur;
    push_pix.red       = in_ch.in_red;
    push_pix.green     = in_ch.in_green;
    push_pix.blue      = in_ch.in_blue;
    push_flags.first   = (row_cur == '0) && (col_cur == '0);
    push_flags.emit    = active && (row_inc >= (FW+1)'(f_eff))
                         && (col_inc >= (FW+1)'(f_eff));
    push_flags.row_end = last_blk;
  end

  // Advance the raster position
  always_comb begin
    src_col_nxt = src_cur;
    out_col_nxt = out_cur;
    row_nxt     = row_cur;
    col_nxt     = col_cur;
    if (col_inc >= (FW+1)'(f_eff)) begin
      col_nxt     = '0;
      out_col_nxt = out_cur + CW'(1);
    end else begin
      col_nxt = KW'(col_inc);
    end
    if (src_inc >= (CW+1)'(w_eff)) begin
      src_col_nxt = '0;
      col_nxt     = '0;
      out_col_nxt = '0;
      row_nxt     = (row_inc >= (FW+1)'(f_eff)) ? '0 : KW'(row_inc);
    end else begin
      src_col_nxt = CW'(src_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      out_col_r <= '0;
      row_r     <= '0;
      col_r     <= '0;
    end else if (accept) begin
      src_col_r <= src_col_nxt;
      out_col_r <= out_col_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rbd_queue.sv
// rbd_queue: small register FIFO between the front and back of the
// downscaler. Depends on rbd_pkg for its depth.
`default_nettype none

module rbd_queue #(
  parameter int DATA_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);

  localparam int DEPTH = rbd_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [AW-1:0]     wptr_r;
  logic [AW-1:0]     rptr_r;
  logic [AW:0]       count_r;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = count_r != (AW+1)'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push_fire) wptr_r <= wptr_r + AW'(1);
      if (pop_fire)  rptr_r <= rptr_r + AW'(1);
      if (push_fire && !pop_fire) begin
        count_r <= count_r + (AW+1)'(1);
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - (AW+1)'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push_fire) slot_r[wptr_r] <= push_data;
  end

endmodule

`default_nettype wire

>>> hdl/rbd_back.sv
// rbd_back: read-modify-write of the per-column sum line, then division of
// finished block sums by F*F through a reciprocal multiply. Depends on rbd_pkg, rbd_if.
`default_nettype none

module rbd_back #(
  parameter int MAX_WIDTH  = rbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = rbd_pkg::DEF_MAX_FACTOR
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [$clog2(MAX_FACTOR+1)-1:0] f_eff,
  input  wire logic                           q_valid,
  output logic                                q_ready,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]    q_addr,
  input  wire rbd_pkg::rbd_pix_t              q_pix,
  input  wire rbd_pkg::rbd_flags_t            q_flags,
  rbd_out_if.source                           out_ch
);

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int FW       = $clog2(MAX_FACTOR + 1);
  localparam int KW       = $clog2(MAX_FACTOR);
  localparam int PIX_W    = rbd_pkg::PIX_W;
  // A band never holds more than MAX_FACTOR x MAX_FACTOR pixels per column
  localparam int SUM_W    = PIX_W + 2 * KW;
  // floor(s / a) == (s * ceil(2^SH / a)) >> SH for every s < 2^SUM_W, a <= 2^(2*KW)
  localparam int RCP_SH   = SUM_W + 2 * KW;
  localparam int RCP_W    = RCP_SH + 1;
  localparam int PROD_W   = SUM_W + RCP_W;
  localparam int MEAN_MAX = (2 ** PIX_W) - 1;

  // Reciprocal of F*F for each factor
  logic [RCP_W-1:0] rcp_tab [MAX_FACTOR];

  for (genvar i = 0; i < MAX_FACTOR; i++) begin : g_rcp
    localparam longint unsigned AREA = longint'(i + 1) * longint'(i + 1);
    localparam longint unsigned RCP  = ((64'd1 << RCP_SH) + AREA - 64'd1) / AREA;
    assign rcp_tab[i] = RCP_W'(RCP);
  end

  // Sum line: one word of three channel sums per output column
  logic [3*SUM_W-1:0] sum_mem [MAX_WIDTH];

  logic                      s1_v_r;
  logic [CW-1:0]             s1_addr_r;
  rbd_pkg::rbd_pix_t         s1_pix_r;
  rbd_pkg::rbd_flags_t       s1_flags_r;
  logic [2:0][SUM_W-1:0]     rd_data_r;
  logic [2:0][SUM_W-1:0]     fwd_sum_r;
  logic                      fwd_sel_r;
  logic                      s2_v_r;
  logic [2:0][SUM_W-1:0]     s2_sum_r;
  logic                      s2_row_end_r;
  logic                      s3_v_r;
  logic [2:0][PROD_W-1:0]    s3_prod_r;
  logic                      s3_row_end_r;
  logic                      out_v_r;
  logic [2:0][PIX_W-1:0]     out_mean_r;
  logic                      out_row_end_r;
  logic [RCP_W-1:0]          rcp_r;

  logic [KW-1:0]             f_idx;
  logic [2:0][PIX_W-1:0]     s1_chan;
  logic [2:0][SUM_W-1:0]     base;
  logic [2:0][SUM_W-1:0]     sum_comb;
  logic [2:0][SUM_W:0]       quot;
  logic [2:0][PIX_W-1:0]     mean_comb;
  logic                      out_free;
  logic                      s3_free;
  logic                      s2_free;
  logic                      s1_go;
  logic                      s1_free;

  // Stage flow: each stage moves when the one after it has room
  assign out_free = !out_v_r || out_ch.ready;
  assign s3_free  = !s3_v_r || out_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_go    = s1_v_r && (!s1_flags_r.emit || s2_free);
  assign s1_free  = !s1_v_r || s1_go;
  assign q_ready  = s1_free;

  assign f_idx = KW'(f_eff - FW'(1));

  // Accumulate: fresh at block start, else add to stored or just-written sum
  assign s1_chan = s1_pix_r;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (s1_flags_r.first) begin
        base[c] = '0;
      end else begin
        base[c] = fwd_sel_r ? fwd_sum_r[c] : rd_data_r[c];
      end
      sum_comb[c] = base[c] + SUM_W'(s1_chan[c]);
    end
  end

  // Quotient and saturation
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quot[c]      = s3_prod_r[c][PROD_W-1:RCP_SH];
      mean_comb[c] = (quot[c] > (SUM_W+1)'(MEAN_MAX)) ? PIX_W'(MEAN_MAX)
                                                       : quot[c][PIX_W-1:0];
    end
  end

  // Sum line write on retire, registered read on pop
  always_ff @(posedge clk) begin
    if (s1_go)   sum_mem[s1_addr_r] <= sum_comb;
    if (s1_free) rd_data_r <= sum_mem[q_addr];
  end

  // Stage valids and bypass select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fwd_sel_r <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r    <= q_valid;
        fwd_sel_r <= s1_go && (s1_addr_r == q_addr);
      end
      if (s2_free)  s2_v_r  <= s1_go && s1_flags_r.emit;
      if (s3_free)  s3_v_r  <= s2_v_r;
      if (out_free) out_v_r <= s3_v_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    rcp_r <= rcp_tab[f_idx];
    if (s1_free) begin
      s1_addr_r  <= q_addr;
      s1_pix_r   <= q_pix;
      s1_flags_r <= q_flags;
      fwd_sum_r  <= sum_comb;
    end
    if (s2_free) begin
      s2_sum_r     <= sum_comb;
      s2_row_end_r <= s1_flags_r.row_end;
    end
    if (s3_free) begin
      for (int c = 0; c < 3; c++) begin
        s3_prod_r[c] <= PROD_W'(s2_sum_r[c]) * PROD_W'(rcp_r);
      end
      s3_row_end_r <= s2_row_end_r;
    end
    if (out_free) begin
      out_mean_r    <= mean_comb;
      out_row_end_r <= s3_row_end_r;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_red   = out_mean_r[2];
  assign out_ch.out_green = out_mean_r[1];
  assign out_ch.out_blue  = out_mean_r[0];
  assign out_ch.row_end   = out_row_end_r;

endmodule

`default_nettype wire

>>> hdl/rgb_box_downscaler.sv
// rgb_box_downscaler: top level; configuration registers, front counters,
// queue and sum/divide back end. Depends on rbd_pkg, rbd_if, rbd_front, rbd_queue, rbd_back.
`default_nettype none

// Shrinks a raster RGB stream by an integer factor F (1..MAX_FACTOR): each
// output pixel is the truncated per-channel mean of one F x F block, and the
// last block of every output row carries row_end. Partial blocks at the right
// and bottom edges are dropped; frame_start restarts the raster position.
// The block takes one pixel per clock while the output keeps up, set by the
// sum line's single write and single registered read per cycle (a bypass covers
// a column that is hit again right after it was written). A block's last pixel
// passes through the queue and the s1, s2, s3 and output registers; a four-entry
// queue lets input continue while the output waits. The sum line has no clearing pass and
// the block is ready straight out of reset. Registers: reduce_factor (index 0,
// 0 acts as 1, above MAX_FACTOR clamps) and src_width (index 1, 0 acts as 1,
// above MAX_WIDTH clamps); write them only between frames or while idle.

module rgb_box_downscaler #(
  parameter int MAX_WIDTH  = rbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = rbd_pkg::DEF_MAX_FACTOR
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  rbd_in_if.sink                               in_ch,
  rbd_out_if.source                            out_ch,
  input  wire logic                            cfg_wr_en,
  input  wire logic [rbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rbd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_FACTOR + 1);
  localparam int Q_W = CW + $bits(rbd_pkg::rbd_pix_t) + $bits(rbd_pkg::rbd_flags_t);

  localparam logic [FW-1:0] F_RST = FW'((rbd_pkg::FACTOR_RST > MAX_FACTOR) ?
                                        MAX_FACTOR : rbd_pkg::FACTOR_RST);
  localparam logic [CW:0]   W_RST = (CW+1)'((rbd_pkg::WIDTH_RST > MAX_WIDTH) ?
                                        MAX_WIDTH : rbd_pkg::WIDTH_RST);

  logic [FW-1:0]                      f_eff_r, f_eff_nxt;
  logic [CW:0]                        w_eff_r, w_eff_nxt;
  logic [rbd_pkg::FACTOR_REG_W-1:0]   f_raw;
  logic [rbd_pkg::WIDTH_REG_W-1:0]    w_raw;

  logic                               push_valid;
  logic                               push_ready;
  logic [CW-1:0]                      push_addr;
  rbd_pkg::rbd_pix_t                  push_pix;
  rbd_pkg::rbd_flags_t                push_flags;
  logic                               pop_valid;
  logic                               pop_ready;
  logic [Q_W-1:0]                     pop_data;
  logic [CW-1:0]                      pop_addr;
  rbd_pkg::rbd_pix_t                  pop_pix;
  rbd_pkg::rbd_flags_t                pop_flags;

  // Clamp written values to the supported range
  assign f_raw = cfg_wdata[rbd_pkg::FACTOR_REG_W-1:0];
  assign w_raw = cfg_wdata[rbd_pkg::WIDTH_REG_W-1:0];

  always_comb begin
    if (f_raw == '0) begin
      f_eff_nxt = FW'(1);
    end else if (32'(f_raw) > MAX_FACTOR) begin
      f_eff_nxt = FW'(MAX_FACTOR);
    end else begin
      f_eff_nxt = FW'(f_raw);
    end
    if (w_raw == '0) begin
      w_eff_nxt = (CW+1)'(1);
    end else if (32'(w_raw) > MAX_WIDTH) begin
      w_eff_nxt = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff_nxt = (CW+1)'(w_raw);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_eff_r <= F_RST;
      w_eff_r <= W_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rbd_pkg::CFG_IDX_FACTOR: f_eff_r <= f_eff_nxt;
        rbd_pkg::CFG_IDX_WIDTH:  w_eff_r <= w_eff_nxt;
        default: ;
      endcase
    end
  end

  rbd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .f_eff      (f_eff_r),
    .w_eff      (w_eff_r),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_addr  (push_addr),
    .push_pix   (push_pix),
    .push_flags (push_flags)
  );

  rbd_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_addr, push_pix, push_flags}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {pop_addr, pop_pix, pop_flags} = pop_data;

  rbd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .f_eff   (f_eff_r),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_addr  (pop_addr),
    .q_pix   (pop_pix),
    .q_flags (pop_flags),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

>>> hdl/rbd_checker.sv
// rbd_checker: port-level assertions for rgb_box_downscaler, and the bind
// that attaches them. Depends on rbd_pkg and the top level's ports.
`default_nettype none

module rbd_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [rbd_pkg::PIX_W-1:0] out_red,
  input wire logic [rbd_pkg::PIX_W-1:0] out_green,
  input wire logic [rbd_pkg::PIX_W-1:0] out_blue,
  input wire logic                      row_end
);

  // A result offered and not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output transfer withdrawn while stalled");

  // Reset empties the pipeline and opens the input
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not cleared by reset");

  // Queue only fills on an accepted pixel
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input ready dropped without a transfer");

  // No mean can leave sooner than the pipeline depth after reset
  a_min_latency: assert property (@(posedge clk)
    !rst_n |=> ##4 !out_valid)
    else $error("result appeared faster than the pipeline allows");

  // Payload ports are observed so the checker sees the whole result channel
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_red, out_green, out_blue, row_end}))
    else $error("result payload unknown while offered");

endmodule

bind rgb_box_downscaler rbd_checker u_rbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.out_red),
  .out_green (out_ch.out_green),
  .out_blue  (out_ch.out_blue),
  .row_end   (out_ch.row_end)
);

`default_nettype wire

>>> verif/rgb_box_downscaler_test.sv
// rgb_box_downscaler_test: self-checking bench for the RGB box downscaler.
// Random idling on both channels; block means are predicted per taken pixel.
// Depends on rbd_pkg, rbd_if and rgb_box_downscaler from the hdl folder.
`timescale 1ns / 100ps

module rgb_box_downscaler_test;
  import rbd_pkg::*;

  localparam int RANDOM_PX     = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 1000000;

  // Source pixel as queued for the driver, block mean as expected on the output
  typedef struct packed {
    rbd_pix_t pix;
    logic     frame_start;
  } src_px_t;

  typedef struct packed {
    rbd_pix_t pix;
    logic     row_end;
  } mean_px_t;

  typedef struct {
    bit [15:0] r;
    bit [15:0] g;
    bit [15:0] b;
  } chan_sum_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rbd_in_if  src_ch ();
  rbd_out_if mean_ch ();

  rgb_box_downscaler u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (src_ch),
    .out_ch   (mean_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Stimulus and scoreboard storage
  src_px_t  pending_px[$];
  mean_px_t expected_means[$];
  int       queued_cnt;
  int       accepted_cnt;
  int       checked_cnt;
  int       error_cnt;
  int       random_px_cnt;
  int       setting_cnt;
  int       cycle_cnt;
  int       send_idle_pct;
  int       recv_idle_pct;

  // Predictor state: register copies, raster position and per-column sums
  bit [4:0]  factor_reg;
  bit [12:0] width_reg;
  bit [12:0] col_pos;
  bit [12:0] blk_idx;
  bit [4:0]  band_row;
  bit [4:0]  block_col;
  chan_sum_t band_sum [DEF_MAX_WIDTH];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_factor(input bit [4:0] raw);
    if (raw == 0) return 1;
    if (raw > DEF_MAX_FACTOR) return DEF_MAX_FACTOR;
    return raw;
  endfunction

  function automatic int unsigned eff_width(input bit [12:0] raw);
    if (raw == 0) return 1;
    if (raw > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return raw;
  endfunction

  function automatic bit [7:0] block_mean(input bit [15:0] sum, input int unsigned area);
    int unsigned q;
    q = sum / area;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Advance the raster position by one pixel; returns 1 when a block completes
  function automatic bit predict_mean(input src_px_t px, output mean_px_t res);
    int unsigned f;
    int unsigned w;
    int unsigned ncols;
    bit          hit;
    f     = eff_factor(factor_reg);
    w     = eff_width(width_reg);
    ncols = w / f;
    hit   = 1'b0;
    res   = '0;
    if (px.frame_start) begin
      col_pos   = '0;
      blk_idx   = '0;
      band_row  = '0;
      block_col = '0;
    end
    // Columns past the last whole block are counted but not summed
    if (blk_idx < ncols) begin
      if (band_row == 0 && block_col == 0) begin
        band_sum[blk_idx].r = px.pix.red;
        band_sum[blk_idx].g = px.pix.green;
        band_sum[blk_idx].b = px.pix.blue;
      end else begin
        band_sum[blk_idx].r += px.pix.red;
        band_sum[blk_idx].g += px.pix.green;
        band_sum[blk_idx].b += px.pix.blue;
      end
      if (band_row + 1 >= f && block_col + 1 >= f) begin
        res.pix.red   = block_mean(band_sum[blk_idx].r, f * f);
        res.pix.green = block_mean(band_sum[blk_idx].g, f * f);
        res.pix.blue  = block_mean(band_sum[blk_idx].b, f * f);
        res.row_end   = (blk_idx + 1 == ncols);
        hit = 1'b1;
      end
    end
    block_col++;
    if (block_col >= f) begin
      block_col = '0;
      blk_idx++;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos   = '0;
      blk_idx   = '0;
      block_col = '0;
      band_row++;
      if (band_row >= f) band_row = '0;
    end
    return hit;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_cnt++;
    end
  endtask

  // Source driver: next pixel goes out once the current one has transferred
  always @(posedge clk) begin : drive_src
    src_px_t next_px;
    if (!rst_n) begin
      src_ch.valid <= 1'b0;
    end else if (!src_ch.valid || src_ch.ready) begin
      if (pending_px.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_px = pending_px.pop_front();
        src_ch.valid       <= 1'b1;
        src_ch.in_red      <= next_px.pix.red;
        src_ch.in_green    <= next_px.pix.green;
        src_ch.in_blue     <= next_px.pix.blue;
        src_ch.frame_start <= next_px.frame_start;
      end else begin
        src_ch.valid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(posedge clk) begin
    mean_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin : watch_ports
    src_px_t  taken;
    mean_px_t want;
    if (rst_n) begin
      if (src_ch.valid && src_ch.ready) begin
        taken.pix.red     = src_ch.in_red;
        taken.pix.green   = src_ch.in_green;
        taken.pix.blue    = src_ch.in_blue;
        taken.frame_start = src_ch.frame_start;
        accepted_cnt++;
        if (predict_mean(taken, want)) expected_means.push_back(want);
      end
      if (mean_ch.valid && mean_ch.ready) begin
        if (expected_means.size() == 0) begin
          $error("block mean with none expected: r=%0d g=%0d b=%0d row_end=%0d",
                 mean_ch.out_red, mean_ch.out_green, mean_ch.out_blue, mean_ch.row_end);
          error_cnt++;
        end else begin
          want = expected_means.pop_front();
          check_field("out_red", want.pix.red, mean_ch.out_red);
          check_field("out_green", want.pix.green, mean_ch.out_green);
          check_field("out_blue", want.pix.blue, mean_ch.out_blue);
          check_field("row_end", want.row_end, mean_ch.row_end);
          checked_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d means outstanding", cycle_cnt,
             expected_means.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_px(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b,
                         input bit fs);
    src_px_t px;
    px.pix.red     = r;
    px.pix.green   = g;
    px.pix.blue    = b;
    px.frame_start = fs;
    pending_px.push_back(px);
    queued_cnt++;
  endtask

  function automatic bit [7:0] rand_chan();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    return $urandom_range(255);
  endfunction

  // Wait until every queued pixel has transferred and every mean has arrived,
  // then let the pipeline empty of pixels that produce nothing
  task automatic drain();
    while (accepted_cnt != queued_cnt || expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while idle, so the predictor copy changes at the same point
  task automatic write_regs(input bit [4:0] factor, input bit [12:0] width);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_FACTOR;
    cfg_wdata <= {8'd0, factor};
    @(posedge clk);
    cfg_index <= CFG_IDX_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    factor_reg = factor;
    width_reg  = width;
    setting_cnt++;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Random pixels from the top left corner of a fresh frame
  task automatic push_raster(input int unsigned count);
    for (int unsigned k = 0; k < count; k++)
      push_px(rand_chan(), rand_chan(), rand_chan(), k == 0);
  endtask

  // One frame of whole bands, sometimes with an unfinished band or cut short;
  // stray frame starts restart the raster now and then
  task automatic push_frame(input int unsigned f, input int unsigned w, input bit lead_start);
    int unsigned rows;
    int unsigned total;
    rows = f * $urandom_range(1, (f > 4) ? 1 : 3);
    if ($urandom_range(3) == 0) rows += $urandom_range(f - 1);
    total = rows * w;
    if ($urandom_range(4) == 0) total = $urandom_range(1, total);
    for (int unsigned k = 0; k < total; k++)
      push_px(rand_chan(), rand_chan(), rand_chan(),
              (k == 0 && lead_start) || $urandom_range(79) == 0);
    random_px_cnt += total;
  endtask

  initial begin : stimulus
    bit [4:0]    factor_raw;
    bit [12:0]   width_raw;
    int unsigned f;
    int unsigned ncols;
    int unsigned sel;
    int unsigned nframes;

    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    src_ch.valid       = 1'b0;
    src_ch.in_red      = '0;
    src_ch.in_green    = '0;
    src_ch.in_blue     = '0;
    src_ch.frame_start = 1'b0;
    mean_ch.ready      = 1'b0;
    factor_reg         = FACTOR_RST;
    width_reg          = WIDTH_RST;
    col_pos            = '0;
    blk_idx            = '0;
    band_row           = '0;
    block_col          = '0;
    set_idle(25, 79);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Zero factor and zero width both act as 1: every pixel is its own row
    write_regs(5'd0, 13'd0);
    push_px(8'd0, 8'd0, 8'd0, 1'b1);
    push_px(8'd255, 8'd255, 8'd255, 1'b0);
    push_px(8'd255, 8'd0, 8'd170, 1'b0);
    push_px(8'd85, 8'd255, 8'd0, 1'b1);
    drain();

    // Factor 2 over width 5: two blocks, one dropped right column, then an
    // unfinished band that the next frame start throws away
    write_regs(5'd2, 13'd5);
    push_px(8'd255, 8'd0, 8'd85, 1'b1);
    push_px(8'd255, 8'd0, 8'd85, 1'b0);
    push_px(8'd1, 8'd254, 8'd0, 1'b0);
    push_px(8'd2, 8'd253, 8'd0, 1'b0);
    push_px(8'd77, 8'd77, 8'd77, 1'b0);
    push_px(8'd255, 8'd0, 8'd85, 1'b0);
    push_px(8'd255, 8'd0, 8'd85, 1'b0);
    push_px(8'd3, 8'd252, 8'd0, 1'b0);
    push_px(8'd4, 8'd255, 8'd1, 1'b0);
    push_px(8'd99, 8'd99, 8'd99, 1'b0);
    push_px(8'd12, 8'd34, 8'd56, 1'b0);
    push_px(8'd200, 8'd100, 8'd50, 1'b1);
    drain();

    // Random settings and frames; idling pattern moves on by thirds
    while (random_px_cnt < RANDOM_PX) begin
      if (random_px_cnt < RANDOM_PX / 3) set_idle(25, 79);
      else if (random_px_cnt < 2 * RANDOM_PX / 3) set_idle(79, 25);
      else set_idle(0, 0);
      sel = $urandom_range(19);
      if (sel == 0) factor_raw = 5'd0;
      else if (sel == 1) factor_raw = $urandom_range(DEF_MAX_FACTOR + 1, 31);
      else if (sel < 4) factor_raw = $urandom_range(5, DEF_MAX_FACTOR);
      else factor_raw = $urandom_range(1, 4);
      f     = eff_factor(factor_raw);
      ncols = (f > 4) ? $urandom_range(1, 2) : $urandom_range(1, 8);
      if ($urandom_range(14) == 0) ncols = 0;
      width_raw = f * ncols + $urandom_range(f - 1);
      write_regs(factor_raw, width_raw);
      nframes = $urandom_range(1, 3);
      for (int unsigned k = 0; k < nframes; k++)
        push_frame(f, eff_width(width_raw), k == 0 || $urandom_range(5) != 0);
      drain();
    end

    // Register extremes, including clamping of both registers
    set_idle(0, 0);
    write_regs(5'd31, 13'd40);
    push_raster(16 * 40);
    drain();
    write_regs(5'd16, 13'd17);
    push_raster(16 * 17);
    drain();
    write_regs(5'd1, 13'd4096);
    push_raster(4097);
    drain();
    write_regs(5'd1, 13'd8191);
    push_raster(4100);
    drain();

    $display("summary: %0d pixels transferred, %0d block means checked, %0d register settings",
             accepted_cnt, checked_cnt, setting_cnt);
    $display("summary: factors 0..31 and widths 0..8191 with sender and receiver idling");
    if (error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
